>>> hdl/pfrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfrc_pkg: shared types and constants of the PCM format and rate converter
// Register indexes, rate codes, the command passed from the front to the back
// and the offset-binary helper functions.
// ----------------------------------------------------------------------------
package pfrc_pkg;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_IS_16BIT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_IS_16BIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_IS_STEREO = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_IS_STEREO = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_MODE     = 3'd4;

	// Rate mode codes; the unused codes behave as same rate.
	localparam logic [2:0] RATE_SAME  = 3'd0;
	localparam logic [2:0] RATE_DEC2  = 3'd1;
	localparam logic [2:0] RATE_DEC4  = 3'd2;
	localparam logic [2:0] RATE_UP2   = 3'd3;
	localparam logic [2:0] RATE_UP4   = 3'd4;

	localparam logic [7:0] U8_BIAS = 8'h80;
	localparam logic [SAMPLE_W-1:0] S16_BIAS = 16'h8000;

	// What the back end has to emit for one queued frame.
	typedef enum logic [1:0] {
		KIND_PASS = 2'd0,
		KIND_UP2  = 2'd1,
		KIND_UP4  = 2'd2
	} pfrc_kind_t;

	typedef struct packed {
		pfrc_kind_t          kind;
		logic                dst_16bit;
		logic                dst_stereo;
		logic [SAMPLE_W-1:0] prev_left;
		logic [SAMPLE_W-1:0] prev_right;
		logic [SAMPLE_W-1:0] cur_left;
		logic [SAMPLE_W-1:0] cur_right;
	} pfrc_cmd_t;

	// Target-format sample to offset binary; the mapping is its own inverse.
	function automatic logic [SAMPLE_W-1:0] to_biased(input logic [SAMPLE_W-1:0] v,
			input logic d16);
		return d16 ? (v ^ S16_BIAS) : {8'h00, v[7:0]};
	endfunction

	function automatic logic [SAMPLE_W-1:0] from_biased(input logic [SAMPLE_W-1:0] v,
			input logic d16);
		return d16 ? (v ^ S16_BIAS) : {8'h00, v[7:0]};
	endfunction

endpackage : pfrc_pkg
`default_nettype wire

>>> hdl/pfrc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfrc_front: frame intake and classification
// Holds the configuration, converts bit depth and channel count, tracks the
// previous frame and the decimation phase, and queues a command per frame that decimation keeps.
// ----------------------------------------------------------------------------
module pfrc_front
	import pfrc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  accept,
	input  wire logic [SAMPLE_W-1:0]   left_raw,
	input  wire logic [SAMPLE_W-1:0]   right_raw,
	input  wire logic                  stream_end,
	output logic                       push,
	output pfrc_cmd_t                  cmd
);

	logic       src16_q, dst16_q, src_st_q, dst_st_q;
	logic [2:0] rate_q;

	logic [SAMPLE_W-1:0] prev_l_q, prev_r_q;
	logic                have_prev_q;
	logic [1:0]          phase_q;

	logic [SAMPLE_W-1:0] dl, dr, cl, cr, mix;
	logic                is_dec, is_up;
	logic [1:0]          mask, phase_next;
	logic                emit;
	pfrc_kind_t          kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src16_q  <= 1'b0;
			dst16_q  <= 1'b0;
			src_st_q <= 1'b0;
			dst_st_q <= 1'b0;
			rate_q   <= RATE_SAME;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SRC_IS_16BIT:  src16_q  <= cfg_wdata[0];
				CFG_DST_IS_16BIT:  dst16_q  <= cfg_wdata[0];
				CFG_SRC_IS_STEREO: src_st_q <= cfg_wdata[0];
				CFG_DST_IS_STEREO: dst_st_q <= cfg_wdata[0];
				CFG_RATE_MODE:     rate_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	function automatic logic [SAMPLE_W-1:0] conv_depth(input logic [SAMPLE_W-1:0] v,
			input logic s16, input logic d16);
		logic [SAMPLE_W-1:0] r;
		unique case ({s16, d16})
			2'b11:   r = v;
			2'b00:   r = {8'h00, v[7:0]};
			2'b01:   r = {v[7:0] ^ U8_BIAS, 8'h00};
			default: r = {8'h00, v[15:8] ^ U8_BIAS};
		endcase
		return r;
	endfunction

	always_comb begin
		dl  = conv_depth(left_raw, src16_q, dst16_q);
		dr  = conv_depth(right_raw, src16_q, dst16_q);
		mix = from_biased((to_biased(dl, dst16_q) >> 1) + (to_biased(dr, dst16_q) >> 1),
			dst16_q);
		if (!src_st_q) begin
			cl = dl;
			cr = dl;
		end else if (!dst_st_q) begin
			cl = mix;
			cr = mix;
		end else begin
			cl = dl;
			cr = dr;
		end

		is_dec     = (rate_q == RATE_DEC2) || (rate_q == RATE_DEC4);
		is_up      = ((rate_q == RATE_UP2) || (rate_q == RATE_UP4)) && have_prev_q;
		mask       = (rate_q == RATE_DEC2) ? 2'b01 : 2'b11;
		phase_next = (phase_q + 2'd1) & mask;
		emit       = !is_dec || ((phase_q & mask) == 2'b00);
		if (!is_up) begin
			kind = KIND_PASS;
		end else if (rate_q == RATE_UP2) begin
			kind = KIND_UP2;
		end else begin
			kind = KIND_UP4;
		end
	end

	assign push = accept && emit;

	always_comb begin
		cmd.kind       = kind;
		cmd.dst_16bit  = dst16_q;
		cmd.dst_stereo = dst_st_q;
		cmd.prev_left  = prev_l_q;
		cmd.prev_right = prev_r_q;
		cmd.cur_left   = cl;
		cmd.cur_right  = cr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_l_q    <= '0;
			prev_r_q    <= '0;
			have_prev_q <= 1'b0;
			phase_q     <= 2'b00;
		end else if (accept) begin
			if (stream_end) begin
				prev_l_q    <= '0;
				prev_r_q    <= '0;
				have_prev_q <= 1'b0;
				phase_q     <= 2'b00;
			end else begin
				prev_l_q    <= cl;
				prev_r_q    <= cr;
				have_prev_q <= 1'b1;
				if (is_dec) begin
					phase_q <= phase_next;
				end
			end
		end
	end

endmodule : pfrc_front
`default_nettype wire

>>> hdl/pfrc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfrc_queue: command queue between front and back
// A small register FIFO; the head entry is visible while not empty.
// ----------------------------------------------------------------------------
module pfrc_queue
	import pfrc_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  pfrc_cmd_t push_cmd,
	input  wire logic pop,
	output logic      full,
	output logic      empty,
	output pfrc_cmd_t head
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	pfrc_cmd_t       entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule : pfrc_queue
`default_nettype wire

>>> hdl/pfrc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfrc_back: result sequencer
// Walks the head command one result per cycle while the output is not stalled,
// computing the interpolated frames, and drives the registered output channel.
// ----------------------------------------------------------------------------
module pfrc_back
	import pfrc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  pfrc_cmd_t                head,
	input  wire logic                empty,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [SAMPLE_W-1:0]      left_out,
	output logic [SAMPLE_W-1:0]      right_out,
	output logic                     run_last
);

	logic [1:0]          step_q;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] left_q, right_q;
	logic                last_q;

	logic       advance, fire, is_last;
	logic [1:0] last_step, wp, wn, sh;
	logic [SAMPLE_W-1:0] res_l, res_r;

	// (wp*prev + wn*cur) >> sh in offset binary; weights are at most three.
	function automatic logic [SAMPLE_W-1:0] blend(input logic [SAMPLE_W-1:0] p,
			input logic [SAMPLE_W-1:0] n, input logic [1:0] w_p, input logic [1:0] w_n,
			input logic [1:0] s, input logic d16);
		logic [SAMPLE_W+1:0] bp, bn, sum, shifted;
		bp  = {2'b00, to_biased(p, d16)};
		bn  = {2'b00, to_biased(n, d16)};
		sum = (w_p[1] ? (bp << 1) : '0) + (w_p[0] ? bp : '0)
			+ (w_n[1] ? (bn << 1) : '0) + (w_n[0] ? bn : '0);
		shifted = sum >> s;
		return from_biased(shifted[SAMPLE_W-1:0], d16);
	endfunction

	always_comb begin
		wp = 2'd0;
		wn = 2'd1;
		sh = 2'd0;
		last_step = 2'd0;
		unique case (head.kind)
			KIND_UP2: begin
				last_step = 2'd1;
				if (step_q == 2'd0) begin
					wp = 2'd1;
					sh = 2'd1;
				end
			end
			KIND_UP4: begin
				last_step = 2'd3;
				unique case (step_q)
					2'd0: begin
						wp = 2'd3;
						sh = 2'd2;
					end
					2'd1: begin
						wp = 2'd1;
						sh = 2'd1;
					end
					2'd2: begin
						wp = 2'd1;
						wn = 2'd3;
						sh = 2'd2;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		res_l = blend(head.prev_left, head.cur_left, wp, wn, sh, head.dst_16bit);
		res_r = blend(head.prev_right, head.cur_right, wp, wn, sh, head.dst_16bit);
	end

	assign advance = !out_valid_q || !out_stall;
	assign fire    = advance && !empty;
	assign is_last = (step_q == last_step);
	assign pop     = fire && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= 2'd0;
		end else begin
			if (advance) begin
				out_valid_q <= !empty;
			end
			if (fire) begin
				step_q <= is_last ? 2'd0 : step_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			left_q  <= res_l;
			right_q <= head.dst_stereo ? res_r : '0;
			last_q  <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = left_q;
	assign right_out = right_q;
	assign run_last  = last_q;

endmodule : pfrc_back
`default_nettype wire

>>> hdl/pcm_format_rate_converter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// A frame's first result passes through the command queue and then the registered output
// stage, and is held there while the output is stalled.
// The back-end sequencer gives one result per cycle while the output is not stalled;
// a frame gives one result at same rate or decimation and, once a frame of the sound has
// been seen, two when upsampling by two and four when upsampling by four.
// Frames dropped by decimation produce no result and are not queued.
// ----------------------------------------------------------------------------
// pcm_format_rate_converter_top: PCM sample format and rate converter
// Converts one PCM frame per input transaction in bit depth, channel count and
// sample rate, and emits zero to four result frames per input transaction.
// Reset (arst_n low, asynchronous) clears configuration, history, queue and
// output valid.
// ----------------------------------------------------------------------------
module pcm_format_rate_converter_top
	import pfrc_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Configuration write port.
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	// Input frame channel.
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [SAMPLE_W-1:0]   left_raw,
	input  wire logic [SAMPLE_W-1:0]   right_raw,
	input  wire logic                  stream_end,
	// Result frame channel.
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [SAMPLE_W-1:0]        left_out,
	output logic [SAMPLE_W-1:0]        right_out,
	output logic                       run_last
);

	logic      accept, push, pop, full, empty;
	pfrc_cmd_t cmd, head;

	// The front takes a transaction whenever the queue has room, so the
	// input side never waits on the output handshake directly.
	assign in_stall = full;
	assign accept   = in_valid && !in_stall;

	// Front: configuration, depth and channel conversion, history tracking
	// and the decision of how many results the frame produces.
	pfrc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.accept     (accept),
		.left_raw   (left_raw),
		.right_raw  (right_raw),
		.stream_end (stream_end),
		.push       (push),
		.cmd        (cmd)
	);

	// Queue of frame commands; it decouples the intake from the sequencer.
	pfrc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (cmd),
		.pop      (pop),
		.full     (full),
		.empty    (empty),
		.head     (head)
	);

	// Back: one result per cycle into the output register, which only
	// advances when it is empty or the consumer takes its transaction.
	pfrc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.left_out  (left_out),
		.right_out (right_out),
		.run_last  (run_last)
	);

endmodule : pcm_format_rate_converter_top
`default_nettype wire

>>> hdl/pfrc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfrc_checker: port-level checks of the converter
// Watches the top-level ports, including a shadow of the target format bits.
// ----------------------------------------------------------------------------
module pfrc_checker
	import pfrc_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  cfg_we,
	input wire logic [CFG_IDX_W-1:0]  cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic [SAMPLE_W-1:0]   left_out,
	input wire logic [SAMPLE_W-1:0]   right_out,
	input wire logic                  run_last
);

	logic dst16_q, dst_st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst16_q  <= 1'b0;
			dst_st_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_DST_IS_16BIT) begin
				dst16_q <= cfg_wdata[0];
			end
			if (cfg_index == CFG_DST_IS_STEREO) begin
				dst_st_q <= cfg_wdata[0];
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result transaction withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(left_out) && $stable(right_out)
			&& $stable(run_last))
		else $error("stalled result payload changed");

	a_mono_right_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !dst_st_q |-> right_out == '0)
		else $error("right sample not zero for a mono target");

	a_byte_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !dst16_q |-> left_out[15:8] == 8'h00 && right_out[15:8] == 8'h00)
		else $error("high byte set for an 8-bit target");

endmodule : pfrc_checker

bind pcm_format_rate_converter_top pfrc_checker u_pfrc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.cfg_index (cfg_index),
	.cfg_wdata (cfg_wdata),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.left_out  (left_out),
	.right_out (right_out),
	.run_last  (run_last)
);
`default_nettype wire
